@@ rtl/assert_macros.svh @@
// assertion helpers used by the checker file
// both expect clk and rst_n in the scope where they are used
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled while in reset
`define LTSE_ASSERT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

// next-cycle implication, disabled while in reset
`define LTSE_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

@@ rtl/ltse_pkg.sv @@
`default_nettype none

package ltse_pkg;

  // field widths
  localparam int unsigned ErrW   = 11;
  localparam int unsigned SensW  = 4;
  localparam int unsigned CountW = 3;
  localparam int unsigned TickW  = 8;
  localparam int unsigned PhaseW = 6;
  localparam int unsigned DirW   = 6;

  // action codes
  localparam logic ACT_SAMPLE  = 1'b0;
  localparam logic ACT_RESTART = 1'b1;

  // lost phase boundaries
  localparam logic [TickW-1:0] COAST_TICKS = 8'd10;
  localparam logic [TickW-1:0] SWEEP_SPLIT = 8'd20;
  localparam logic [TickW-1:0] SEARCH_END  = 8'd30;
  localparam logic [TickW-1:0] TICK_MAX    = 8'd255;
  localparam logic [TickW-1:0] TIMEOUT_RST = 8'd200;

  // swing period
  localparam logic [PhaseW-1:0] SWING_HALF = 6'd20;
  localparam logic [PhaseW-1:0] SWING_FULL = 6'd40;

  // error levels in tenths of a millimetre
  localparam logic signed [ErrW-1:0] OUTER_ERR = 11'sd300;
  localparam logic signed [ErrW-1:0] SWEEP_ERR = 11'sd200;
  localparam logic signed [ErrW-1:0] SWING_ERR = 11'sd400;

  // recorded drift directions in millimetres
  localparam logic signed [DirW-1:0] DIR_ONE   = 6'sd1;
  localparam logic signed [DirW-1:0] DIR_OUTER = 6'sd30;

  typedef logic signed [ErrW-1:0] err_t;
  typedef logic signed [DirW-1:0] dir_t;

  // tracking state carried from one sample to the next
  typedef struct packed {
    logic [TickW-1:0]  lost_ticks;
    logic [PhaseW-1:0] swing_phase;
    dir_t              last_direction;
    logic              never_on_line;
    err_t              held_error;
  } track_t;

  // one result transaction
  typedef struct packed {
    err_t              error_tenths;
    logic [SensW-1:0]  sensor_echo;
    logic [CountW-1:0] line_count;
    logic              on_line;
    logic              lost_flag;
  } result_t;

endpackage

`default_nettype wire

@@ rtl/ltse_if.sv @@
`default_nettype none

// sample channel
interface ltse_in_if;
  import ltse_pkg::*;
  logic             valid;
  logic             ready;
  logic             action;
  logic [SensW-1:0] sensor_bits;

  modport source (output valid, output action, output sensor_bits, input ready);
  modport sink   (input valid, input action, input sensor_bits, output ready);
endinterface

// steering result channel
interface ltse_out_if;
  import ltse_pkg::*;
  logic              valid;
  logic              ready;
  err_t              error_tenths;
  logic [SensW-1:0]  sensor_echo;
  logic [CountW-1:0] line_count;
  logic              on_line;
  logic              lost_flag;

  modport source (output valid, output error_tenths, output sensor_echo,
                  output line_count, output on_line, output lost_flag, input ready);
  modport sink   (input valid, input error_tenths, input sensor_echo,
                  input line_count, input on_line, input lost_flag, output ready);
endinterface

`default_nettype wire

@@ rtl/ltse_step.sv @@
`default_nettype none

module ltse_step (
  input  ltse_pkg::track_t         cur,
  input  logic                     action,
  input  logic [3:0]               sensor_bits,
  input  logic [7:0]               lost_timeout,
  output ltse_pkg::track_t         nxt,
  output ltse_pkg::result_t        res
);
  import ltse_pkg::*;

  logic              lo, lc, rc, ro;
  logic [CountW-1:0] count;
  logic [TickW-1:0]  n;
  logic [PhaseW-1:0] phase_inc;
  logic signed [11:0] search_prod;

  assign lo = sensor_bits[3];
  assign lc = sensor_bits[2];
  assign rc = sensor_bits[1];
  assign ro = sensor_bits[0];

  assign count = CountW'(lo) + CountW'(lc) + CountW'(rc) + CountW'(ro);

  // saturating lost count and next swing position
  assign n = (cur.lost_ticks == TICK_MAX) ? TICK_MAX : cur.lost_ticks + 8'd1;
  assign phase_inc = cur.swing_phase + 6'd1;

  // amplified search: direction times lost ticks (ticks below 31 here)
  assign search_prod = cur.last_direction * $signed({1'b0, n[4:0]});

  // tracking update
  always_comb begin
    nxt = cur;
    if (action == ACT_RESTART) begin
      nxt.lost_ticks     = '0;
      nxt.swing_phase    = '0;
      nxt.last_direction = '0;
      nxt.never_on_line  = 1'b1;
      nxt.held_error     = '0;
    end else if (lc || rc) begin
      nxt.held_error    = '0;
      nxt.lost_ticks    = '0;
      nxt.swing_phase   = '0;
      nxt.never_on_line = 1'b0;
      if (lc && !rc) begin
        nxt.last_direction = -DIR_ONE;
      end else if (rc && !lc) begin
        nxt.last_direction = DIR_ONE;
      end else begin
        nxt.last_direction = '0;
      end
    end else if (lo || ro) begin
      nxt.lost_ticks    = '0;
      nxt.swing_phase   = '0;
      nxt.never_on_line = 1'b0;
      if (lo && !ro) begin
        nxt.last_direction = -DIR_OUTER;
        nxt.held_error     = -OUTER_ERR;
      end else if (ro && !lo) begin
        nxt.last_direction = DIR_OUTER;
        nxt.held_error     = OUTER_ERR;
      end else begin
        nxt.last_direction = '0;
        nxt.held_error     = '0;
      end
    end else begin
      nxt.lost_ticks = n;
      if (n <= COAST_TICKS) begin
        nxt.held_error = '0;
      end else if (n <= SEARCH_END) begin
        if (cur.never_on_line || (cur.last_direction == '0)) begin
          nxt.held_error = (n <= SWEEP_SPLIT) ? -SWEEP_ERR : SWEEP_ERR;
        end else begin
          nxt.held_error = search_prod[ErrW-1:0];
        end
      end else if (n < lost_timeout) begin
        nxt.swing_phase = phase_inc;
        if (phase_inc < SWING_HALF) begin
          nxt.held_error = -SWING_ERR;
        end else if (phase_inc < SWING_FULL) begin
          nxt.held_error = SWING_ERR;
        end else begin
          nxt.swing_phase = '0;
        end
      end else begin
        nxt.held_error = '0;
      end
    end
  end

  // result fields, all zero for a restart
  always_comb begin
    if (action == ACT_RESTART) begin
      res = '0;
    end else begin
      res.error_tenths = nxt.held_error;
      res.sensor_echo  = sensor_bits;
      res.line_count   = count;
      res.on_line      = (count != '0);
      res.lost_flag    = (nxt.lost_ticks != '0);
    end
  end

endmodule

`default_nettype wire

@@ rtl/line_track_steering_error_unit.sv @@
`default_nettype none

// Line tracker steering error. Each sample transaction (four sensor bits, or a
// restart action) yields exactly one result transaction carrying the steering
// error in tenths of a millimetre, the echoed sensor bits, the count of sensors
// on the line and the on-line and lost flags. The tracking state and the result
// are computed from the accepted sample and registered, so the result shows
// on the output in the cycle after acceptance and a new sample can be taken every
// cycle; throughput is one transaction per clock, held back only when the
// output register is full and not being drained. cfg_we writes lost_timeout
// (reset 200), the lost tick count at which the swinging search ends; write it
// only while no transaction is in flight.
module line_track_steering_error_unit (
  input  logic       clk,
  input  logic       rst_n,
  ltse_in_if.sink    in_ch,
  ltse_out_if.source out_ch,
  input  logic       cfg_we,
  input  logic [7:0] cfg_wdata
);
  import ltse_pkg::*;

  track_t  track_r, track_nxt;
  result_t res_r, res_nxt;
  logic    out_valid_r;
  logic [TickW-1:0] timeout_r;
  logic    in_acc;

  // accept while the output register is empty or emptying
  assign in_ch.ready = !out_valid_r || out_ch.ready;
  assign in_acc      = in_ch.valid && in_ch.ready;

  ltse_step u_step (
    .cur          (track_r),
    .action       (in_ch.action),
    .sensor_bits  (in_ch.sensor_bits),
    .lost_timeout (timeout_r),
    .nxt          (track_nxt),
    .res          (res_nxt)
  );

  // tracking state, timeout register and output valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      track_r.lost_ticks     <= '0;
      track_r.swing_phase    <= '0;
      track_r.last_direction <= '0;
      track_r.never_on_line  <= 1'b1;
      track_r.held_error     <= '0;
      timeout_r              <= TIMEOUT_RST;
      out_valid_r            <= 1'b0;
    end else begin
      if (cfg_we) begin
        timeout_r <= cfg_wdata;
      end
      if (in_acc) begin
        track_r     <= track_nxt;
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // result payload
  always_ff @(posedge clk) begin
    if (in_acc) begin
      res_r <= res_nxt;
    end
  end

  assign out_ch.valid        = out_valid_r;
  assign out_ch.error_tenths = res_r.error_tenths;
  assign out_ch.sensor_echo  = res_r.sensor_echo;
  assign out_ch.line_count   = res_r.line_count;
  assign out_ch.on_line      = res_r.on_line;
  assign out_ch.lost_flag    = res_r.lost_flag;

endmodule

`default_nettype wire

@@ rtl/ltse_checker.sv @@
`default_nettype none

`include "assert_macros.svh"

module ltse_checker (
  input wire        clk,
  input wire        rst_n,
  input wire        in_valid,
  input wire        in_ready,
  input wire        in_action,
  input wire        out_valid,
  input wire        out_ready,
  input wire [10:0] out_error_tenths,
  input wire [3:0]  out_sensor_echo,
  input wire [2:0]  out_line_count,
  input wire        out_on_line,
  input wire        out_lost_flag
);

  wire out_all_zero;

  // every result field cleared
  assign out_all_zero = (out_error_tenths == 11'd0) && (out_sensor_echo == 4'd0) &&
                        (out_line_count == 3'd0) && !out_on_line && !out_lost_flag;

  // a stalled result stays offered
  `LTSE_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid)
  // every accepted sample shows a result on the next cycle
  `LTSE_ASSERT_NEXT(a_result_latency, in_valid && in_ready, out_valid)
  // a restart reports an all-zero result
  `LTSE_ASSERT_NEXT(a_restart_zero, in_valid && in_ready && in_action, out_all_zero)
  // seeing the line clears the lost count
  `LTSE_ASSERT(a_on_line_not_lost, out_valid && out_on_line, !out_lost_flag && out_line_count != 3'd0)

endmodule

bind line_track_steering_error_unit ltse_checker u_ltse_checker (
  .clk              (clk),
  .rst_n            (rst_n),
  .in_valid         (in_ch.valid),
  .in_ready         (in_ch.ready),
  .in_action        (in_ch.action),
  .out_valid        (out_ch.valid),
  .out_ready        (out_ch.ready),
  .out_error_tenths (out_ch.error_tenths),
  .out_sensor_echo  (out_ch.sensor_echo),
  .out_line_count   (out_ch.line_count),
  .out_on_line      (out_ch.on_line),
  .out_lost_flag    (out_ch.lost_flag)
);

`default_nettype wire

@@ tb/tb_line_track_steering_error_unit.sv @@
module tb_line_track_steering_error_unit;
  timeunit 1ns;
  timeprecision 1ps;

  import ltse_pkg::*;

  logic       clk = 1'b0;
  logic       rst_n;
  logic       cfg_we;
  logic [7:0] cfg_wdata;

  ltse_in_if  in_ch ();
  ltse_out_if out_ch ();

  line_track_steering_error_unit dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  // 12 ns clock
  always #6 clk = ~clk;

  // tracker state as the block should hold it
  track_t           trk;
  logic [TickW-1:0] model_timeout;
  result_t          expected_steer_q[$];
  result_t          front;

  // sender burst control
  int unsigned burst_left    = 0;
  bit          steady_sender = 1'b0;

  // run statistics
  int unsigned items_sent   = 0;
  int unsigned results_seen = 0;
  int unsigned mismatches   = 0;
  int unsigned n_restarts   = 0;
  int unsigned n_swing      = 0;
  int unsigned n_saturated  = 0;
  int unsigned n_settings   = 0;

  // run watchdog
  initial begin
    #5_000_000;
    $display("FAIL");
    $finish;
  end

  // tracking state after restart
  function automatic void clear_tracker();
    trk = '0;
    trk.never_on_line = 1'b1;
  endfunction

  // next steering result for one accepted sample transaction
  function automatic result_t predict_steering(input logic act, input logic [SensW-1:0] bits);
    result_t          r;
    logic             lo, lc, rc, ro;
    logic [TickW-1:0] factor;
    lo = bits[3];
    lc = bits[2];
    rc = bits[1];
    ro = bits[0];
    r  = '0;
    if (act == ACT_RESTART) begin
      clear_tracker();
      n_restarts++;
      return r;
    end
    if (lc || rc) begin
      // centre sensor on the line: zero error, remember drift
      trk.held_error    = '0;
      trk.lost_ticks    = '0;
      trk.swing_phase   = '0;
      trk.never_on_line = 1'b0;
      if (lc && !rc) trk.last_direction = -DIR_ONE;
      else if (rc && !lc) trk.last_direction = DIR_ONE;
      else trk.last_direction = '0;
    end else if (lo || ro) begin
      // outer sensor only
      if (lo && !ro) begin
        trk.last_direction = -DIR_OUTER;
        trk.held_error     = -OUTER_ERR;
      end else if (ro && !lo) begin
        trk.last_direction = DIR_OUTER;
        trk.held_error     = OUTER_ERR;
      end else begin
        trk.last_direction = '0;
        trk.held_error     = '0;
      end
      trk.lost_ticks    = '0;
      trk.swing_phase   = '0;
      trk.never_on_line = 1'b0;
    end else begin
      // line lost: saturating count picks the search phase
      if (trk.lost_ticks != TICK_MAX) trk.lost_ticks++;
      else n_saturated++;
      if (trk.lost_ticks <= COAST_TICKS) begin
        trk.held_error = '0;
      end else if (trk.lost_ticks <= SEARCH_END) begin
        if (trk.never_on_line || trk.last_direction == '0) begin
          trk.held_error = (trk.lost_ticks <= SWEEP_SPLIT) ? -SWEEP_ERR : SWEEP_ERR;
        end else begin
          factor = (trk.lost_ticks < SEARCH_END) ? trk.lost_ticks : SEARCH_END;
          trk.held_error = err_t'(int'($signed(trk.last_direction)) * int'(factor));
        end
      end else if (trk.lost_ticks < model_timeout) begin
        n_swing++;
        trk.swing_phase++;
        if (trk.swing_phase < SWING_HALF) trk.held_error = -SWING_ERR;
        else if (trk.swing_phase < SWING_FULL) trk.held_error = SWING_ERR;
        else trk.swing_phase = '0;
      end else begin
        trk.held_error = '0;
      end
    end
    r.error_tenths = trk.held_error;
    r.sensor_echo  = bits;
    r.line_count   = CountW'($countones(bits));
    r.on_line      = |bits;
    r.lost_flag    = |trk.lost_ticks;
    return r;
  endfunction

  // drive one sample transaction, bursts separated by random gaps
  task automatic send_sample(input logic act, input logic [SensW-1:0] bits);
    int unsigned gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap = steady_sender ? 0 : $urandom_range(0, 7);
      if (gap != 0) begin
        in_ch.valid <= 1'b0;
        repeat (gap) @(negedge clk);
      end
    end
    in_ch.valid       <= 1'b1;
    in_ch.action      <= act;
    in_ch.sensor_bits <= bits;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    expected_steer_q.push_back(predict_steering(act, bits));
    items_sent++;
    burst_left--;
    @(negedge clk);
  endtask

  // run of samples with no sensor on the line
  task automatic lose_line(input int unsigned ticks);
    repeat (ticks) send_sample(ACT_SAMPLE, '0);
  endtask

  // register write once the block has drained
  task automatic write_lost_timeout(input logic [TickW-1:0] value);
    in_ch.valid <= 1'b0;
    while (expected_steer_q.size() != 0) @(posedge clk);
    repeat (2) @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    @(negedge clk);
    cfg_we        <= 1'b0;
    model_timeout  = value;
    n_settings++;
  endtask

  // every sensor pattern and restart with ignored bits
  task automatic test_sensor_patterns();
    send_sample(ACT_RESTART, 4'hF);
    for (int i = 0; i < 16; i++) send_sample(ACT_SAMPLE, 4'(i));
    send_sample(ACT_RESTART, 4'hA);
    send_sample(ACT_SAMPLE, 4'h0);
    send_sample(ACT_RESTART, 4'h5);
  endtask

  // each lost phase from each kind of remembered direction
  task automatic test_lost_phases();
    send_sample(ACT_RESTART, 4'h0);
    lose_line(32);
    send_sample(ACT_SAMPLE, 4'b0100);
    lose_line(45);
    send_sample(ACT_SAMPLE, 4'b0001);
    lose_line(31);
    send_sample(ACT_SAMPLE, 4'b1001);
    lose_line(25);
    send_sample(ACT_SAMPLE, 4'b0110);
    lose_line(22);
    // full swing period and timeout
    send_sample(ACT_SAMPLE, 4'b1000);
    lose_line(205);
  endtask

  // lost runs under extreme and random timeout settings, up to counter saturation
  task automatic test_timeout_settings();
    logic [TickW-1:0] values[5];
    values = '{8'd31, 8'd32, 8'd255, 8'd0, 8'($urandom_range(33, 90))};
    foreach (values[i]) begin
      write_lost_timeout(values[i]);
      send_sample(ACT_SAMPLE, 4'b0010);
      lose_line(values[i] > 8'd50 ? int'(values[i]) + 4 : 45);
    end
  endtask

  // random on-line/lost sequences with some noise and restarts
  task automatic test_random_tracking();
    int unsigned start, next_cfg, pick, len;
    start    = items_sent;
    next_cfg = 0;
    while (items_sent - start < 200) begin
      if (items_sent - start >= next_cfg) begin
        pick = $urandom_range(0, 4);
        case (pick)
          0: write_lost_timeout(8'd0);
          1: write_lost_timeout(8'd31);
          2: write_lost_timeout(8'd255);
          3: write_lost_timeout(TIMEOUT_RST);
          default: write_lost_timeout(8'($urandom_range(0, 255)));
        endcase
        next_cfg += 50;
      end
      steady_sender = ($urandom_range(0, 4) == 0);
      pick = $urandom_range(0, 9);
      if (pick == 0) begin
        send_sample(ACT_RESTART, 4'($urandom_range(0, 15)));
      end else if (pick == 1) begin
        repeat ($urandom_range(1, 5))
          send_sample(1'($urandom_range(0, 1)), 4'($urandom_range(0, 15)));
      end else begin
        repeat ($urandom_range(1, 4)) send_sample(ACT_SAMPLE, 4'($urandom_range(1, 15)));
        pick = $urandom_range(0, 9);
        if (pick < 6) len = $urandom_range(0, 12);
        else if (pick < 9) len = $urandom_range(11, 45);
        else len = $urandom_range(46, 260);
        lose_line(len);
      end
    end
    steady_sender = 1'b0;
  endtask

  // result ready stalls, one of four patterns picked at random and held for a random run
  initial begin
    int unsigned mode = 0;
    int unsigned left = 0;
    out_ch.ready <= 1'b0;
    forever begin
      @(negedge clk);
      if (left == 0) begin
        mode = $urandom_range(0, 3);
        left = $urandom_range(20, 80);
      end
      left--;
      case (mode)
        0: out_ch.ready <= 1'b1;
        1: out_ch.ready <= 1'($urandom_range(0, 1));
        2: out_ch.ready <= (left % 5) != 0;
        default: out_ch.ready <= (left % 16) < 4;
      endcase
    end
  end

  // one field of a result against its expectation
  task automatic check_field(input string field, input int want, input int got);
    if (want != got) begin
      mismatches++;
      if (mismatches <= 10)
        $display("mismatch in %s at %0t: expected %0d, got %0d", field, $realtime, want, got);
    end
  endtask

  // compare each result transaction with the oldest expectation
  always @(posedge clk) begin
    if (rst_n && out_ch.valid && out_ch.ready) begin
      results_seen++;
      if (expected_steer_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result at %0t: error %0d, sensors %h", $realtime,
                   out_ch.error_tenths, out_ch.sensor_echo);
      end else begin
        front = expected_steer_q.pop_front();
        check_field("error_tenths", int'(front.error_tenths), int'(out_ch.error_tenths));
        check_field("sensor_echo", int'(front.sensor_echo), int'(out_ch.sensor_echo));
        check_field("line_count", int'(front.line_count), int'(out_ch.line_count));
        check_field("on_line", int'(front.on_line), int'(out_ch.on_line));
        check_field("lost_flag", int'(front.lost_flag), int'(out_ch.lost_flag));
      end
    end
  end

  // reset, tests in turn, drain and verdict
  initial begin
    in_ch.valid       <= 1'b0;
    in_ch.action      <= ACT_SAMPLE;
    in_ch.sensor_bits <= '0;
    cfg_we            <= 1'b0;
    cfg_wdata         <= '0;
    rst_n             <= 1'b0;
    clear_tracker();
    model_timeout = TIMEOUT_RST;
    repeat (12) @(negedge clk);
    rst_n <= 1'b1;

    test_sensor_patterns();
    test_lost_phases();
    test_timeout_settings();
    test_random_tracking();

    in_ch.valid <= 1'b0;
    while (expected_steer_q.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);

    $display("sent %0d samples (%0d restarts), %0d results checked, %0d timeout writes",
             items_sent, n_restarts, results_seen, n_settings);
    $display("swing ticks %0d, ticks at saturated lost count %0d, mismatches %0d",
             n_swing, n_saturated, mismatches);
    if (mismatches == 0 && expected_steer_q.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
